// ----- hw/rtl/icb_pkg.sv -----
// icb_pkg: shared types, register map and constants for interval_counter_bank.
// No dependencies.
package icb_pkg;

  localparam int BANK_SIZE_DEF = 32;

  localparam int OP_W       = 2;
  localparam int INDEX_W    = 5;
  localparam int VALUE_W    = 64;
  localparam int MASK_W     = 32;
  localparam int INTERVAL_W = 40;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 64;

  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;
  localparam logic [OP_W-1:0] OP_FLIP = 2'd3;

  // register select is paddr[3]: 8-byte register slots
  localparam logic REG_AGGREGATE_MASK = 1'b0;
  localparam logic REG_INTERVAL       = 1'b1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 40'd1000000000;
  localparam logic [VALUE_W-1:0]    SIGN_BIAS      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic capture;   // latch the accepted input word
    logic execute;   // apply the operation and load the output register
  } icb_cmd_t;

endpackage

// ----- hw/rtl/icb_regs.sv -----
// icb_regs: APB configuration registers (aggregate mask, interval).
// Depends on icb_pkg.
module icb_regs import icb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  output logic [MASK_W-1:0]     aggregate_mask,
  output logic [INTERVAL_W-1:0] interval
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aggregate_mask <= '0;
      interval       <= INTERVAL_RESET;
    end else if (wr_en) begin
      case (paddr[3])
        REG_AGGREGATE_MASK: aggregate_mask <= pwdata[MASK_W-1:0];
        REG_INTERVAL:       interval       <= pwdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_AGGREGATE_MASK: prdata = PDATA_W'(aggregate_mask);
      REG_INTERVAL:       prdata = PDATA_W'(interval);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/icb_ctrl.sv -----
// icb_ctrl: two-state sequencer and output valid for interval_counter_bank.
// Depends on icb_pkg.
module icb_ctrl import icb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output icb_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state, state_next;
  logic out_valid, out_valid_next;

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = out_valid;
  assign cmd.capture = s_tvalid & s_tready;
  assign cmd.execute = (state == ST_EXEC) & (~out_valid | m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.capture) state_next = ST_EXEC;
      ST_EXEC: if (cmd.execute) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/icb_datapath.sv -----
// icb_datapath: counter bank, snapshot bank, flip timer and output register.
// Depends on icb_pkg; driven by icb_ctrl commands.
module icb_datapath import icb_pkg::*; #(
  parameter int BANK_SIZE = BANK_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  icb_cmd_t              cmd,
  input  logic [OP_W-1:0]       op,
  input  logic [INDEX_W-1:0]    index,
  input  logic [VALUE_W-1:0]    amount,
  input  logic [VALUE_W-1:0]    now,
  input  logic [MASK_W-1:0]     aggregate_mask,
  input  logic [INTERVAL_W-1:0] interval,
  output logic [VALUE_W-1:0]    data,
  output logic                  aggregated
);

  localparam int MASK_EXT_W = (BANK_SIZE > MASK_W) ? BANK_SIZE : MASK_W;

  logic [OP_W-1:0]       op_r;
  logic [INDEX_W-1:0]    index_r;
  logic [VALUE_W-1:0]    amount_r;
  logic [VALUE_W-1:0]    now_r;

  logic [VALUE_W-1:0]    live [BANK_SIZE];
  logic [VALUE_W-1:0]    snap [BANK_SIZE];
  logic [VALUE_W-1:0]    last_flip_time;

  logic [MASK_EXT_W-1:0] mask_ext;
  logic [BANK_SIZE-1:0]  hit;
  logic [BANK_SIZE-1:0]  agg;
  logic [VALUE_W-1:0]    sel_live;
  logic [VALUE_W-1:0]    sel_snap;
  logic                  sel_agg;
  logic [VALUE_W-1:0]    load_value;
  logic [VALUE_W-1:0]    sum;
  logic [VALUE_W:0]      threshold;
  logic                  fire;

  assign mask_ext = MASK_EXT_W'(aggregate_mask);

  // counters past the mask width are never aggregating (mask_ext is zero there)
  always_comb begin
    sel_live = '0;
    sel_snap = '0;
    sel_agg  = 1'b0;
    for (int i = 0; i < BANK_SIZE; i++) begin
      hit[i] = (int'(index_r) == i);
      agg[i] = mask_ext[i];
      if (hit[i]) begin
        sel_live = sel_live | live[i];
        sel_snap = sel_snap | snap[i];
        sel_agg  = sel_agg | agg[i];
      end
    end
  end

  assign load_value = sel_agg ? sel_snap : sel_live;
  assign sum        = sel_live + amount_r;

  // signed compare done in biased unsigned order, threshold kept one bit wider
  assign threshold = {1'b0, last_flip_time ^ SIGN_BIAS} + (VALUE_W+1)'(interval);
  assign fire      = (op_r == OP_FLIP) & ({1'b0, now_r ^ SIGN_BIAS} > threshold);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op;
      index_r  <= index;
      amount_r <= amount;
      now_r    <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANK_SIZE; i++) begin
        live[i] <= '0;
        snap[i] <= '0;
      end
      last_flip_time <= '0;
    end else if (cmd.execute) begin
      case (op_r)
        OP_SET: begin
          for (int i = 0; i < BANK_SIZE; i++) begin
            if (hit[i]) live[i] <= amount_r;
          end
        end
        OP_ADD: begin
          for (int i = 0; i < BANK_SIZE; i++) begin
            if (hit[i]) live[i] <= sum;
          end
        end
        OP_FLIP: begin
          if (fire) begin
            for (int i = 0; i < BANK_SIZE; i++) begin
              if (agg[i]) begin
                snap[i] <= live[i];
                live[i] <= '0;
              end
            end
            last_flip_time <= now_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      data       <= (op_r == OP_LOAD) ? load_value : '0;
      aggregated <= fire;
    end
  end

endmodule

// ----- hw/rtl/interval_counter_bank.sv -----
// interval_counter_bank: top level, bank of 64-bit counters with timed snapshots.
// Depends on icb_pkg, icb_regs, icb_ctrl, icb_datapath.
//
//  channel | handshake                     | payload
//  s       | s_tvalid / s_tready           | tuser: op; tdata: index, amount, now
//  m       | m_tvalid / m_tready           | tuser: aggregated; tdata: data
//  apb     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Each word is accepted, then executed in the datapath by the two-state
// sequencer. Flips update all aggregating counters at once.
// The output register lets the next word be accepted while a result waits.
// A stalled m_tready holds the sequencer in execute.
module interval_counter_bank import icb_pkg::*; #(
  parameter int BANK_SIZE = BANK_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [135:0]       s_tdata,   // index[4:0], amount[68:5], now[132:69], zero pad
  input  logic [OP_W-1:0]    s_tuser,   // op[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,   // data[63:0]
  output logic [0:0]         m_tuser,   // aggregated[0]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  icb_cmd_t              cmd;
  logic [MASK_W-1:0]     aggregate_mask;
  logic [INTERVAL_W-1:0] interval;

  icb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .aggregate_mask (aggregate_mask),
    .interval       (interval)
  );

  icb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  icb_datapath #(
    .BANK_SIZE (BANK_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (s_tuser),
    .index          (s_tdata[4:0]),
    .amount         (s_tdata[68:5]),
    .now            (s_tdata[132:69]),
    .aggregate_mask (aggregate_mask),
    .interval       (interval),
    .data           (m_tdata),
    .aggregated     (m_tuser[0])
  );

endmodule

// ----- test/icb_checker.sv -----
// icb_checker: watches the stream and APB channels of interval_counter_bank,
// predicts every result word and compares it with what the block returns.
// Depends on icb_pkg.
module icb_checker import icb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [135:0]       s_tdata,   // index[4:0], amount[68:5], now[132:69], zero pad
  input  logic [OP_W-1:0]    s_tuser,   // op[1:0]
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [VALUE_W-1:0] m_tdata,   // data[63:0]
  input  logic [0:0]         m_tuser,   // aggregated[0]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 errors,
  output int                 outstanding,
  output int                 flips_fired,
  output int                 loads_seen
);

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               aggregated;
  } outcome_t;

  logic [VALUE_W-1:0]    live_count [BANK_SIZE_DEF];
  logic [VALUE_W-1:0]    snap_count [BANK_SIZE_DEF];
  logic [VALUE_W-1:0]    last_flip;
  logic [MASK_W-1:0]     mask_q;
  logic [INTERVAL_W-1:0] interval_q;

  outcome_t due_outcomes [$];
  int       mismatches = 0;
  int       fired = 0;
  int       loads = 0;

  function automatic outcome_t apply_counter_op(input logic [OP_W-1:0] op,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic [VALUE_W-1:0] amount,
                                                input logic [VALUE_W-1:0] now);
    outcome_t           res;
    logic signed [65:0] limit_x;
    logic signed [65:0] now_x;
    res.data = '0;
    res.aggregated = 1'b0;
    case (op)
      OP_SET:  live_count[idx] = amount;
      OP_ADD:  live_count[idx] = live_count[idx] + amount;
      OP_LOAD: res.data = mask_q[idx] ? snap_count[idx] : live_count[idx];
      OP_FLIP: begin
        // exact compare, threshold may pass the signed 64-bit range
        limit_x = $signed({{2{last_flip[63]}}, last_flip}) + $signed({26'd0, interval_q});
        now_x   = $signed({{2{now[63]}}, now});
        if (now_x > limit_x) begin
          for (int i = 0; i < BANK_SIZE_DEF; i++) begin
            if (mask_q[i]) begin
              snap_count[i] = live_count[i];
              live_count[i] = '0;
            end
          end
          last_flip = now;
          res.aggregated = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      live_count = '{default: '0};
      snap_count = '{default: '0};
      last_flip  = '0;
      mask_q     = '0;
      interval_q = INTERVAL_RESET;
      due_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3])
          REG_AGGREGATE_MASK: mask_q = pwdata[MASK_W-1:0];
          REG_INTERVAL:       interval_q = pwdata[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        got = apply_counter_op(s_tuser, s_tdata[4:0], s_tdata[68:5], s_tdata[132:69]);
        if (got.aggregated) fired++;
        if (s_tuser == OP_LOAD) loads++;
        due_outcomes.push_back(got);
      end
      if (m_tvalid && m_tready) begin
        if (due_outcomes.size() == 0) begin
          $error("result word with nothing expected: data %h aggregated %b",
                 m_tdata, m_tuser[0]);
          mismatches++;
        end else begin
          want = due_outcomes.pop_front();
          if (m_tdata !== want.data) begin
            $error("data mismatch: expected %h actual %h", want.data, m_tdata);
            mismatches++;
          end
          if (m_tuser[0] !== want.aggregated) begin
            $error("aggregated mismatch: expected %b actual %b", want.aggregated, m_tuser[0]);
            mismatches++;
          end
        end
      end
    end
    errors      <= mismatches;
    outstanding <= due_outcomes.size();
    flips_fired <= fired;
    loads_seen  <= loads;
  end

endmodule

// ----- test/interval_counter_bank_tb.sv -----
// interval_counter_bank_tb: drives set/add/load/flip words and APB register
// writes into interval_counter_bank under random backpressure.
// Depends on icb_pkg, interval_counter_bank and icb_checker.
module interval_counter_bank_tb;
  import icb_pkg::*;

  localparam logic [VALUE_W-1:0]    S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0]    S64_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [PADDR_W-1:0]    ADDR_MASK     = {REG_AGGREGATE_MASK, 3'b000};
  localparam logic [PADDR_W-1:0]    ADDR_INTERVAL = {REG_INTERVAL, 3'b000};
  localparam int PHASES    = 5;
  localparam int PHASE_LEN = 160;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [135:0]       s_tdata = '0;   // index[4:0], amount[68:5], now[132:69], zero pad
  logic [OP_W-1:0]    s_tuser = '0;   // op[1:0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;        // data[63:0]
  logic [0:0]         m_tuser;        // aggregated[0]
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors;
  int outstanding;
  int flips_fired;
  int loads_seen;

  logic               quiet = 1'b0;
  logic               squeeze_req = 1'b0;
  logic [VALUE_W-1:0] wall_clock = '0;
  int                 words_sent = 0;
  int                 reg_writes = 0;

  interval_counter_bank i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  icb_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .outstanding(outstanding),
    .flips_fired(flips_fired), .loads_seen(loads_seen)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] amount, input logic [VALUE_W-1:0] now);
    int gap;
    gap = quiet ? 0 : pick_pause();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, now, amount, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_FLIP && $signed(now) > $signed(wall_clock)) wall_clock = now;
    words_sent++;
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        hold = quiet ? 0 : pick_pause();
        if (hold == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [MASK_W-1:0]     phase_mask [PHASES];
    logic [INTERVAL_W-1:0] phase_iv [PHASES];
    logic [OP_W-1:0]       op;
    logic [VALUE_W-1:0]    amount;
    logic [VALUE_W-1:0]    now;
    logic [VALUE_W-1:0]    span;
    int                    r;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: nothing aggregates, one-second interval
    send_word(OP_LOAD, 5'd0, '0, '0);
    send_word(OP_SET, 5'd0, S64_MAX, '0);
    send_word(OP_LOAD, 5'd0, '0, '0);
    send_word(OP_ADD, 5'd0, 64'd1, '0);
    send_word(OP_LOAD, 5'd0, '0, '0);
    send_word(OP_SET, 5'd31, S64_MIN, '0);
    send_word(OP_ADD, 5'd31, '1, '0);
    send_word(OP_LOAD, 5'd31, '0, '0);
    send_word(OP_FLIP, 5'd0, '0, 64'd1000000000);
    send_word(OP_FLIP, 5'd0, '0, 64'd1000000001);
    send_word(OP_FLIP, 5'd0, '0, S64_MIN);
    send_word(OP_LOAD, 5'd0, '0, '0);
    settle();

    // all counters aggregating, interval of one
    write_reg(ADDR_MASK, 64'hFFFF_FFFF);
    write_reg(ADDR_INTERVAL, 64'd1);
    send_word(OP_SET, 5'd5, 64'd123, '0);
    send_word(OP_LOAD, 5'd5, '0, '0);
    send_word(OP_FLIP, 5'd0, '0, 64'd1000000002);
    send_word(OP_FLIP, 5'd0, '0, 64'd1000000003);
    send_word(OP_LOAD, 5'd5, '0, '0);
    send_word(OP_LOAD, 5'd0, '0, '0);
    send_word(OP_ADD, 5'd5, 64'd7, '0);
    send_word(OP_LOAD, 5'd5, '0, '0);
    settle();

    phase_mask[0] = $urandom;  phase_iv[0] = 40'd1000;
    phase_mask[1] = '1;        phase_iv[1] = 40'($urandom_range(1, 1 << 20));
    phase_mask[2] = '0;        phase_iv[2] = INTERVAL_RESET;
    phase_mask[3] = $urandom;  phase_iv[3] = INTERVAL_MAX;
    phase_mask[4] = $urandom;  phase_iv[4] = 40'($urandom_range(1, 100));

    for (int p = 0; p < PHASES; p++) begin
      write_reg(ADDR_MASK, {32'd0, phase_mask[p]});
      write_reg(ADDR_INTERVAL, {24'd0, phase_iv[p]});
      quiet = (p == 0);
      if (p == 1) squeeze_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < 22) op = OP_SET;
        else if (r < 50) op = OP_ADD;
        else if (r < 75) op = OP_LOAD;
        else op = OP_FLIP;
        r = $urandom_range(0, 9);
        if (r == 0) amount = S64_MAX;
        else if (r == 1) amount = S64_MIN;
        else if (r < 4) amount = 64'($signed($urandom_range(0, 200)) - 100);
        else amount = {$urandom, $urandom};
        now = {$urandom, $urandom};
        if (op == OP_FLIP) begin
          r = $urandom_range(0, 99);
          if (r < 85) begin
            span = 2 * {24'd0, phase_iv[p]} + 2;
            now = wall_clock + ({$urandom, $urandom} % span);
          end else if (r < 93) begin
            now[63] = 1'b1;
          end else begin
            now = wall_clock - $urandom_range(0, 50);
          end
        end
        send_word(op, 5'($urandom_range(0, 31)), amount, now);
      end
      settle();
    end

    // widest interval, then a threshold past the signed range
    quiet = 1'b0;
    write_reg(ADDR_MASK, 64'hFFFF_FFFF);
    write_reg(ADDR_INTERVAL, {24'd0, INTERVAL_MAX});
    send_word(OP_SET, 5'd9, 64'd42, '0);
    send_word(OP_FLIP, 5'd0, '0, S64_MAX);
    send_word(OP_LOAD, 5'd9, '0, '0);
    send_word(OP_SET, 5'd9, 64'd77, '0);
    send_word(OP_FLIP, 5'd0, '0, S64_MAX);
    send_word(OP_FLIP, 5'd0, '0, S64_MIN);
    send_word(OP_LOAD, 5'd9, '0, '0);
    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d words (%0d loads, %0d flips that aggregated) over %0d register writes",
             words_sent, loads_seen, flips_fired, reg_writes);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
